// ===== hw/rtl/kvv_pkg.sv =====
package kvv_pkg;

  localparam int W = 40;
  localparam int F = 32;
  localparam int NCFG = 8;
  localparam int CNT_BITS = 32;

  // multiplier takes one 8-bit digit of the second operand per cycle
  localparam int MD = (W + 7) / 8;
  localparam int MBW = MD * 8;
  // root of (n2 << F) and quotient of (mu << F)
  localparam int RB = (W + F + 1) / 2;
  localparam int NW = 2 * RB;
  localparam int NUMW = W - 1 + F;
  localparam int ITW = $clog2(NUMW + 1);

  typedef logic signed [W-1:0] word_t;

  localparam word_t MAXV = {1'b0, {(W-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    CFG_GRAVITY = 3'd0,
    CFG_STEP    = 3'd1,
    CFG_SPOS_X  = 3'd2,
    CFG_SPOS_Y  = 3'd3,
    CFG_SPOS_Z  = 3'd4,
    CFG_SVEL_X  = 3'd5,
    CFG_SVEL_Y  = 3'd6,
    CFG_SVEL_Z  = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    SEL_ZERO, SEL_H, SEL_HH,
    SEL_POS0, SEL_POS1, SEL_POS2,
    SEL_VEL0, SEL_VEL1, SEL_VEL2,
    SEL_ACC0, SEL_ACC1, SEL_ACC2,
    SEL_N2, SEL_LEN, SEL_R3, SEL_K, SEL_KE, SEL_PE
  } sel_e;

  localparam int NSEL = 18;

  typedef enum logic [2:0] {
    OP_MAC,   // dst = c + round(a * b), sign inverted by inv
    OP_SQRT,  // dst = floor(sqrt(a << F))
    OP_DIV,   // dst = (mu << F) / |b|
    OP_SKIP,  // restart items jump to the energy part
    OP_END
  } op_e;

  typedef struct packed {
    op_e  op;
    sel_e a;
    sel_e b;
    sel_e c;
    sel_e dst;
    logic inv;
  } uop_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } sum_t;

  localparam logic [4:0] PC_STEP   = 5'd0;
  localparam logic [4:0] PC_ACCEL  = 5'd6;
  localparam logic [4:0] PC_ENERGY = 5'd19;
  localparam logic [4:0] PC_LAST   = 5'd23;

  function automatic uop_t prog(input logic [4:0] pc);
    uop_t u;
    u = '{OP_END, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0};
    case (pc)
      5'd0:  u = '{OP_MAC, SEL_HH, SEL_ACC0, SEL_VEL0, SEL_VEL0, 1'b0};
      5'd1:  u = '{OP_MAC, SEL_H, SEL_VEL0, SEL_POS0, SEL_POS0, 1'b0};
      5'd2:  u = '{OP_MAC, SEL_HH, SEL_ACC1, SEL_VEL1, SEL_VEL1, 1'b0};
      5'd3:  u = '{OP_MAC, SEL_H, SEL_VEL1, SEL_POS1, SEL_POS1, 1'b0};
      5'd4:  u = '{OP_MAC, SEL_HH, SEL_ACC2, SEL_VEL2, SEL_VEL2, 1'b0};
      5'd5:  u = '{OP_MAC, SEL_H, SEL_VEL2, SEL_POS2, SEL_POS2, 1'b0};
      5'd6:  u = '{OP_MAC, SEL_POS0, SEL_POS0, SEL_ZERO, SEL_N2, 1'b0};
      5'd7:  u = '{OP_MAC, SEL_POS1, SEL_POS1, SEL_N2, SEL_N2, 1'b0};
      5'd8:  u = '{OP_MAC, SEL_POS2, SEL_POS2, SEL_N2, SEL_N2, 1'b0};
      5'd9:  u = '{OP_SQRT, SEL_N2, SEL_ZERO, SEL_ZERO, SEL_LEN, 1'b0};
      5'd10: u = '{OP_MAC, SEL_N2, SEL_LEN, SEL_ZERO, SEL_R3, 1'b0};
      5'd11: u = '{OP_DIV, SEL_ZERO, SEL_R3, SEL_ZERO, SEL_K, 1'b0};
      5'd12: u = '{OP_MAC, SEL_K, SEL_POS0, SEL_ZERO, SEL_ACC0, 1'b1};
      5'd13: u = '{OP_MAC, SEL_K, SEL_POS1, SEL_ZERO, SEL_ACC1, 1'b1};
      5'd14: u = '{OP_MAC, SEL_K, SEL_POS2, SEL_ZERO, SEL_ACC2, 1'b1};
      5'd15: u = '{OP_SKIP, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0};
      5'd16: u = '{OP_MAC, SEL_HH, SEL_ACC0, SEL_VEL0, SEL_VEL0, 1'b0};
      5'd17: u = '{OP_MAC, SEL_HH, SEL_ACC1, SEL_VEL1, SEL_VEL1, 1'b0};
      5'd18: u = '{OP_MAC, SEL_HH, SEL_ACC2, SEL_VEL2, SEL_VEL2, 1'b0};
      5'd19: u = '{OP_MAC, SEL_VEL0, SEL_VEL0, SEL_ZERO, SEL_KE, 1'b0};
      5'd20: u = '{OP_MAC, SEL_VEL1, SEL_VEL1, SEL_KE, SEL_KE, 1'b0};
      5'd21: u = '{OP_MAC, SEL_VEL2, SEL_VEL2, SEL_KE, SEL_KE, 1'b0};
      5'd22: u = '{OP_DIV, SEL_ZERO, SEL_LEN, SEL_ZERO, SEL_PE, 1'b0};
      default: u = '{OP_END, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0};
    endcase
    return u;
  endfunction

  function automatic sum_t sadd(input word_t a, input word_t b);
    logic signed [W:0] s;
    sum_t r;
    s = {a[W-1], a} + {b[W-1], b};
    r.sat = s[W] ^ s[W-1];
    if (r.sat) begin
      r.val = s[W] ? MINV : MAXV;
    end else begin
      r.val = s[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [W-1:0] mag(input word_t a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

endpackage

// ===== hw/rtl/kvv_if.sv =====
interface kvv_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface kvv_out_if;
  logic                 valid;
  logic                 ready;
  kvv_pkg::word_t       pos_x;
  kvv_pkg::word_t       pos_y;
  kvv_pkg::word_t       pos_z;
  kvv_pkg::word_t       vel_x;
  kvv_pkg::word_t       vel_y;
  kvv_pkg::word_t       vel_z;
  kvv_pkg::word_t       specific_energy;
  logic [kvv_pkg::CNT_BITS-1:0] step_index;
  logic                 saturated;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output vel_x, output vel_y, output vel_z,
                  output specific_energy, output step_index, output saturated,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input vel_x, input vel_y, input vel_z,
                input specific_energy, input step_index, input saturated,
                output ready);
endinterface

// ===== hw/rtl/kepler_velocity_verlet_step_top.sv =====
// Velocity Verlet step for one body around a central mass, Q8.32 words.
// A word with restart set loads position and velocity from the start
// registers and works out the acceleration; any other word advances one step
// of size h. Every word gives back one result word. The block takes one word
// at a time and is busy until its result is in the output register (which
// may still wait for the sink while the block goes idle again). A micro-
// program of 24 steps drives one shared 40x8 digit multiplier, a 1-bit-per-
// cycle square root and a 1-bit-per-cycle restoring divider (skipped when
// the divisor is zero). A step runs two divisions, one square root and 19
// multiply-adds, a restart two divisions, one square root and 10. Before
// going idle the block may wait for the sink to take the previous result.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must
// write them only while no word is in flight, which the block does not enforce.
module kepler_velocity_verlet_step_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [kvv_pkg::W-1:0] cfg_wdata_i,
  kvv_in_if.sink                in_i,
  kvv_out_if.source             out_o
);

  localparam int W = kvv_pkg::W;
  localparam int F = kvv_pkg::F;
  localparam int MBW = kvv_pkg::MBW;
  localparam int MD = kvv_pkg::MD;
  localparam int RB = kvv_pkg::RB;
  localparam int NW = kvv_pkg::NW;
  localparam int NUMW = kvv_pkg::NUMW;
  localparam int ITW = kvv_pkg::ITW;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_MUL, S_RND, S_ADD, S_SQRT, S_DIV, S_DONE
  } state_e;

  state_e state_q;
  logic [4:0] pc_q;
  logic [ITW-1:0] it_q;
  logic restart_q;
  logic sat_q;
  logic [kvv_pkg::CNT_BITS-1:0] cnt_q;

  logic [W-2:0] mu_q, h_q;
  kvv_pkg::word_t spos_q [3];
  kvv_pkg::word_t svel_q [3];

  kvv_pkg::word_t pos_q [3];
  kvv_pkg::word_t vel_q [3];
  kvv_pkg::word_t acc_q [3];
  kvv_pkg::word_t n2_q, len_q, r3_q, k_q, ke_q, pe_q, t_q;

  // shared units
  logic [W-1:0]   ma_q;
  logic [MBW-1:0] mb_q;
  logic [2*W-1:0] prod_q;
  logic           neg_q;
  logic [NW-1:0]  sq_n_q;
  logic [RB+1:0]  sq_rem_q;
  logic [RB-1:0]  sq_root_q;
  logic [NUMW-1:0] dv_n_q;
  logic [NUMW-1:0] dv_quo_q;
  logic [W-1:0]   dv_rem_q;
  logic [W-1:0]   den_q;

  logic out_valid_q;
  kvv_pkg::word_t o_pos_q [3];
  kvv_pkg::word_t o_vel_q [3];
  kvv_pkg::word_t o_e_q;
  logic [kvv_pkg::CNT_BITS-1:0] o_cnt_q;
  logic o_sat_q;

  kvv_pkg::uop_t uop;
  kvv_pkg::word_t bank [kvv_pkg::NSEL];
  kvv_pkg::word_t opa, opb, opc;
  logic [W-1:0] maga, magb;
  logic in_acc;

  // multiplier
  logic [W+7:0]   pp;
  logic [2*W-1:0] prod_d;
  logic [2*W-1:0] prnd;
  logic [2*W-F-1:0] psh;
  logic           p_over;
  kvv_pkg::word_t p_val;
  kvv_pkg::sum_t  add_r;
  // square root
  logic [RB+3:0]  sq_x;
  logic [RB+3:0]  sq_trial;
  logic           sq_ge;
  // divider
  logic [W:0]     dv_x;
  logic           dv_ge;
  logic [NUMW-1:0] dv_quo_d;
  // energy
  logic [W:0]     ke_inc;
  kvv_pkg::sum_t  e_r;

  always_comb begin
    uop = kvv_pkg::prog(pc_q);
    bank[kvv_pkg::SEL_ZERO] = '0;
    bank[kvv_pkg::SEL_H]    = {1'b0, h_q};
    bank[kvv_pkg::SEL_HH]   = kvv_pkg::word_t'(({2'b00, h_q} + 1'b1) >> 1);
    bank[kvv_pkg::SEL_POS0] = pos_q[0];
    bank[kvv_pkg::SEL_POS1] = pos_q[1];
    bank[kvv_pkg::SEL_POS2] = pos_q[2];
    bank[kvv_pkg::SEL_VEL0] = vel_q[0];
    bank[kvv_pkg::SEL_VEL1] = vel_q[1];
    bank[kvv_pkg::SEL_VEL2] = vel_q[2];
    bank[kvv_pkg::SEL_ACC0] = acc_q[0];
    bank[kvv_pkg::SEL_ACC1] = acc_q[1];
    bank[kvv_pkg::SEL_ACC2] = acc_q[2];
    bank[kvv_pkg::SEL_N2]   = n2_q;
    bank[kvv_pkg::SEL_LEN]  = len_q;
    bank[kvv_pkg::SEL_R3]   = r3_q;
    bank[kvv_pkg::SEL_K]    = k_q;
    bank[kvv_pkg::SEL_KE]   = ke_q;
    bank[kvv_pkg::SEL_PE]   = pe_q;
    opa = bank[uop.a];
    opb = bank[uop.b];
    opc = bank[uop.c];
    maga = kvv_pkg::mag(opa);
    magb = kvv_pkg::mag(opb);
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc = in_i.valid && in_i.ready;

  always_comb begin
    pp = ma_q * mb_q[MBW-1 -: 8];
    prod_d = {prod_q[2*W-9:0], 8'b0} + {{(W-8){1'b0}}, pp};

    // round half away from zero on the magnitude, then clip
    prnd = prod_q + {{(2*W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    psh = prnd[2*W-1:F];
    p_over = (|psh[2*W-F-1:W]) ||
             (neg_q ? (psh[W-1] && (|psh[W-2:0])) : psh[W-1]);
    if (p_over) begin
      p_val = neg_q ? kvv_pkg::MINV : kvv_pkg::MAXV;
    end else begin
      p_val = neg_q ? kvv_pkg::word_t'(~psh[W-1:0] + 1'b1)
                    : kvv_pkg::word_t'(psh[W-1:0]);
    end
    add_r = kvv_pkg::sadd(opc, t_q);

    sq_x = {sq_rem_q, sq_n_q[NW-1 -: 2]};
    sq_trial = {2'b00, sq_root_q, 2'b01};
    sq_ge = (sq_x >= sq_trial);

    dv_x = {dv_rem_q, dv_n_q[NUMW-1]};
    dv_ge = (dv_x >= {1'b0, den_q});
    dv_quo_d = {dv_quo_q[NUMW-2:0], dv_ge};

    ke_inc = {1'b0, ke_q} + 1'b1;
    e_r = kvv_pkg::sadd(kvv_pkg::word_t'(ke_inc >> 1),
                        kvv_pkg::word_t'(~pe_q + 1'b1));
  end

  // operand write-back, one destination per micro-step
  task automatic wb(input kvv_pkg::sel_e d, input kvv_pkg::word_t v);
    case (d)
      kvv_pkg::SEL_POS0: pos_q[0] <= v;
      kvv_pkg::SEL_POS1: pos_q[1] <= v;
      kvv_pkg::SEL_POS2: pos_q[2] <= v;
      kvv_pkg::SEL_VEL0: vel_q[0] <= v;
      kvv_pkg::SEL_VEL1: vel_q[1] <= v;
      kvv_pkg::SEL_VEL2: vel_q[2] <= v;
      kvv_pkg::SEL_ACC0: acc_q[0] <= v;
      kvv_pkg::SEL_ACC1: acc_q[1] <= v;
      kvv_pkg::SEL_ACC2: acc_q[2] <= v;
      kvv_pkg::SEL_N2:   n2_q <= v;
      kvv_pkg::SEL_LEN:  len_q <= v;
      kvv_pkg::SEL_R3:   r3_q <= v;
      kvv_pkg::SEL_K:    k_q <= v;
      kvv_pkg::SEL_KE:   ke_q <= v;
      kvv_pkg::SEL_PE:   pe_q <= v;
      default: ;
    endcase
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0;
      it_q <= '0;
      restart_q <= 1'b0;
      sat_q <= 1'b0;
      cnt_q <= '0;
      mu_q <= (W-1)'(42949673);
      h_q <= (W-1)'(42949673);
      spos_q[0] <= kvv_pkg::word_t'(64'sd4294967296);
      spos_q[1] <= '0;
      spos_q[2] <= kvv_pkg::word_t'(64'sd2147483648);
      svel_q[0] <= kvv_pkg::word_t'(64'sd429496730);
      svel_q[1] <= kvv_pkg::word_t'(64'sd257698038);
      svel_q[2] <= kvv_pkg::word_t'(64'sd85899346);
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        acc_q[i] <= '0;
        o_pos_q[i] <= '0;
        o_vel_q[i] <= '0;
      end
      n2_q <= '0;
      len_q <= '0;
      r3_q <= '0;
      k_q <= '0;
      ke_q <= '0;
      pe_q <= '0;
      t_q <= '0;
      ma_q <= '0;
      mb_q <= '0;
      prod_q <= '0;
      neg_q <= 1'b0;
      sq_n_q <= '0;
      sq_rem_q <= '0;
      sq_root_q <= '0;
      dv_n_q <= '0;
      dv_quo_q <= '0;
      dv_rem_q <= '0;
      den_q <= '0;
      out_valid_q <= 1'b0;
      o_e_q <= '0;
      o_cnt_q <= '0;
      o_sat_q <= 1'b0;
    end else begin
      // S_DONE refills the output register itself
      if (out_valid_q && out_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          kvv_pkg::CFG_GRAVITY: mu_q <= cfg_wdata_i[W-2:0];
          kvv_pkg::CFG_STEP:    h_q <= cfg_wdata_i[W-2:0];
          kvv_pkg::CFG_SPOS_X:  spos_q[0] <= cfg_wdata_i;
          kvv_pkg::CFG_SPOS_Y:  spos_q[1] <= cfg_wdata_i;
          kvv_pkg::CFG_SPOS_Z:  spos_q[2] <= cfg_wdata_i;
          kvv_pkg::CFG_SVEL_X:  svel_q[0] <= cfg_wdata_i;
          kvv_pkg::CFG_SVEL_Y:  svel_q[1] <= cfg_wdata_i;
          kvv_pkg::CFG_SVEL_Z:  svel_q[2] <= cfg_wdata_i;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            restart_q <= in_i.restart;
            sat_q <= 1'b0;
            state_q <= S_FETCH;
            if (in_i.restart) begin
              for (int i = 0; i < 3; i++) begin
                pos_q[i] <= spos_q[i];
                vel_q[i] <= svel_q[i];
              end
              cnt_q <= '0;
              pc_q <= kvv_pkg::PC_ACCEL;
            end else begin
              cnt_q <= cnt_q + 1'b1;
              pc_q <= kvv_pkg::PC_STEP;
            end
          end
        end
        S_FETCH: begin
          it_q <= '0;
          case (uop.op)
            kvv_pkg::OP_MAC: begin
              ma_q <= maga;
              mb_q <= MBW'(magb);
              neg_q <= opa[W-1] ^ opb[W-1] ^ uop.inv;
              prod_q <= '0;
              state_q <= S_MUL;
            end
            kvv_pkg::OP_SQRT: begin
              sq_n_q <= NW'({opa[W-2:0], {F{1'b0}}});
              sq_rem_q <= '0;
              sq_root_q <= '0;
              state_q <= S_SQRT;
            end
            kvv_pkg::OP_DIV: begin
              if (magb == '0) begin
                // zero divisor: largest word, flagged
                wb(uop.dst, kvv_pkg::MAXV);
                sat_q <= 1'b1;
                pc_q <= pc_q + 1'b1;
              end else begin
                den_q <= magb;
                dv_n_q <= {mu_q, {F{1'b0}}};
                dv_rem_q <= '0;
                dv_quo_q <= '0;
                state_q <= S_DIV;
              end
            end
            kvv_pkg::OP_SKIP: begin
              pc_q <= restart_q ? kvv_pkg::PC_ENERGY : pc_q + 1'b1;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          prod_q <= prod_d;
          mb_q <= mb_q << 8;
          it_q <= it_q + 1'b1;
          if (it_q == ITW'(MD - 1)) begin
            state_q <= S_RND;
          end
        end
        S_RND: begin
          t_q <= p_val;
          if (p_over) sat_q <= 1'b1;
          state_q <= S_ADD;
        end
        S_ADD: begin
          wb(uop.dst, add_r.val);
          if (add_r.sat) sat_q <= 1'b1;
          pc_q <= pc_q + 1'b1;
          state_q <= S_FETCH;
        end
        S_SQRT: begin
          sq_n_q <= sq_n_q << 2;
          sq_root_q <= {sq_root_q[RB-2:0], sq_ge};
          sq_rem_q <= sq_ge ? (RB+2)'(sq_x - sq_trial) : (RB+2)'(sq_x);
          it_q <= it_q + 1'b1;
          if (it_q == ITW'(RB - 1)) begin
            wb(uop.dst, kvv_pkg::word_t'({sq_root_q[RB-2:0], sq_ge}));
            pc_q <= pc_q + 1'b1;
            state_q <= S_FETCH;
          end
        end
        S_DIV: begin
          dv_n_q <= dv_n_q << 1;
          dv_quo_q <= dv_quo_d;
          dv_rem_q <= dv_ge ? W'(dv_x - {1'b0, den_q}) : W'(dv_x);
          it_q <= it_q + 1'b1;
          if (it_q == ITW'(NUMW - 1)) begin
            if (|dv_quo_d[NUMW-1:W-1]) begin
              wb(uop.dst, kvv_pkg::MAXV);
              sat_q <= 1'b1;
            end else begin
              wb(uop.dst, kvv_pkg::word_t'(dv_quo_d[W-1:0]));
            end
            pc_q <= pc_q + 1'b1;
            state_q <= S_FETCH;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            for (int i = 0; i < 3; i++) begin
              o_pos_q[i] <= pos_q[i];
              o_vel_q[i] <= vel_q[i];
            end
            o_e_q <= e_r.val;
            o_cnt_q <= cnt_q;
            o_sat_q <= sat_q | e_r.sat;
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.pos_x = o_pos_q[0];
  assign out_o.pos_y = o_pos_q[1];
  assign out_o.pos_z = o_pos_q[2];
  assign out_o.vel_x = o_vel_q[0];
  assign out_o.vel_y = o_vel_q[1];
  assign out_o.vel_z = o_vel_q[2];
  assign out_o.specific_energy = o_e_q;
  assign out_o.step_index = o_cnt_q;
  assign out_o.saturated = o_sat_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input taken while a word is in flight");

  a_pc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (pc_q <= kvv_pkg::PC_LAST))
    else $error("micro-program counter past end");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_q))
    else $error("result appeared without any work");

  a_restart_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.restart) |=> (cnt_q == '0))
    else $error("restart did not clear the step count");

endmodule
